// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the RTL. Each one samples on the rising edge
// of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/bidst_pkg.sv =====
`default_nettype none

package bidst_pkg;

  // Width of a group identifier.
  localparam int ID_W = 23;

  // Action codes. Any other code is treated as a lookup.
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_LOOKUP  = 3'd0,
    ST_ADDED   = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_REMOVED = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  // One request item.
  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] group_id;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       found;
    logic [2:0] status;
    logic [7:0] entry_count;
  } out_item_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic add_en;
    logic rm_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/bidst_cell.sv =====
`default_nettype none

// One slot of the set. It compares its entry against the incoming identifier,
// takes a new identifier when it is the append slot, and takes its upper
// neighbor's entry when a remove compacts the row.
module bidst_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  wire                           clk_i,
  input  wire                           cmp_en_i,
  input  wire  [bidst_pkg::ID_W-1:0]    cmp_id_i,
  input  wire  [bidst_pkg::ID_W-1:0]    wr_id_i,
  input  wire  [CNT_W-1:0]              count_i,
  input  bidst_pkg::cell_cmd_t          cmd_i,
  input  wire                           shift_i,
  input  wire  [bidst_pkg::ID_W-1:0]    nbr_entry_i,
  output logic [bidst_pkg::ID_W-1:0]    entry_o,
  output logic                          match_o
);
  import bidst_pkg::*;

  logic [ID_W-1:0] entry_q;
  logic            match_q;
  logic            occupied;
  logic            is_tail;

  // The slot holds a live entry when its position is below the count.
  assign occupied = (CNT_W'(IDX) < count_i);
  assign is_tail  = (CNT_W'(IDX) == count_i);

  // Compare once, when the request is taken.
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= occupied && (entry_q == cmp_id_i);
    end
  end

  // Append at the tail, or pull the neighbor's entry down on a remove.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en && is_tail) begin
      entry_q <= wr_id_i;
    end else if (cmd_i.rm_en && shift_i) begin
      entry_q <= nbr_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== design/bidst_scan.sv =====
`default_nettype none

// Reduces the per-cell match bits: any hit, and a prefix OR that marks every
// cell at or above the hit position, which are the cells that shift down.
module bidst_scan #(
  parameter int N = 128
) (
  input  wire  [N-1:0] match_i,
  output logic         any_o,
  output logic [N-1:0] shift_o
);

  localparam int STEPS = $clog2(N);

  // Log-depth prefix OR toward higher positions.
  always_comb begin
    logic [N-1:0] p;
    p = match_i;
    for (int s = 0; s < STEPS; s++) begin
      p = p | (p << (1 << s));
    end
    shift_o = p;
  end

  assign any_o = |match_i;

endmodule

`default_nettype wire

// ===== design/bounded_id_set_table_core.sv =====
// Channel   | Direction | Signals                      | Transfer condition
// ----------+-----------+------------------------------+----------------------------
// request   | in        | start_i, busy_o, in_i        | start_i high, busy_o low
// result    | out       | res_strobe_o, res_o          | res_strobe_o high, one cycle
// config    | in        | cfg_valid_i, cfg_ready_o,    | cfg_valid_i and cfg_ready_o
//           |           | cfg_data_i                   |
//
// For each item, every cell compares its entry against the identifier
// at the edge that takes the request, and the next edge applies the update.
// The result is loaded into an output register at the update edge and is shown,
// with its strobe, for the cycle after it, so a new request may be taken at the
// edge that ends that cycle.
// Reset clears the count and busy state; the block takes requests right away.
// The receiver cannot stall results.
`default_nettype none
`include "assert_macros.svh"

module bounded_id_set_table_core #(
  parameter int CAPACITY = 128
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  bidst_pkg::in_item_t   in_i,
  output logic                  res_strobe_o,
  output bidst_pkg::out_item_t  res_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire                   cfg_data_i
);
  import bidst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  busy_q;
  logic [1:0]            act_q;
  logic [ID_W-1:0]       id_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  mon_q;
  logic                  res_strobe_q;
  out_item_t             res_q, res_d;
  logic                  accept;
  cell_cmd_t             cmd;
  logic [CAPACITY-1:0]   match_w;
  logic [CAPACITY-1:0]   shift_w;
  logic [ID_W-1:0]       entry_w [CAPACITY];
  logic                  any_hit;

  assign accept      = start_i && !busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  // Request capture and the single update cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_i.action;
      id_q  <= in_i.group_id;
    end
  end

  // Monitor-all register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mon_q <= cfg_data_i;
    end
  end

  // Row of cells; the last one has no upper neighbor and reloads itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = entry_w[i];
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end

    bidst_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .cmp_en_i    (accept),
      .cmp_id_i    (in_i.group_id),
      .wr_id_i     (id_q),
      .count_i     (count_q),
      .cmd_i       (cmd),
      .shift_i     (shift_w[i]),
      .nbr_entry_i (nbr),
      .entry_o     (entry_w[i]),
      .match_o     (match_w[i])
    );
  end

  bidst_scan #(
    .N (CAPACITY)
  ) u_scan (
    .match_i (match_w),
    .any_o   (any_hit),
    .shift_o (shift_w)
  );

  // Decide the outcome from the registered match bits.
  always_comb begin
    cmd.add_en      = 1'b0;
    cmd.rm_en       = 1'b0;
    count_d         = count_q;
    res_d.found     = 1'b0;
    res_d.status    = ST_LOOKUP;
    unique case (act_q)
      ACT_ADD: begin
        if (id_q == '0) begin
          res_d.status = ST_INVALID;
        end else if (any_hit) begin
          res_d.status = ST_PRESENT;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.status = ST_ADDED;
          cmd.add_en   = busy_q;
          count_d      = count_q + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        res_d.status = ST_REMOVED;
        if (any_hit) begin
          cmd.rm_en = busy_q;
          count_d   = count_q - CNT_W'(1);
        end
      end
      // Lookup, and the unused code that behaves as one.
      default: begin
        res_d.found = mon_q || any_hit;
      end
    endcase
    if (!busy_q) begin
      count_d = count_q;
    end
    res_d.entry_count = 8'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      res_strobe_q <= busy_q;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // Each request holds the update stage for exactly one cycle.
  `ASSERT_NEXT(a_busy_single, busy_q, !busy_q)
  // A result is shown exactly once per update cycle.
  `ASSERT_NEXT(a_strobe_follows, busy_q, res_strobe_q)
  `ASSERT_NEXT(a_no_spurious, !busy_q, !res_strobe_q)
  // Held identifiers are distinct, so at most one cell can hit.
  `ASSERT_IMPL(a_unique_hit, busy_q, $onehot0(match_w))
  // The count never exceeds the capacity.
  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  import bidst_pkg::*;

  localparam int TABLE_DEPTH   = 128;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int POOL_SIZE     = 160;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 250;

  // Action codes that the package leaves unnamed.
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ID_TOP = {1'b1, {(ID_W-1){1'b0}}};
  localparam logic [ID_W-1:0] ID_LOW = {1'b0, {(ID_W-1){1'b1}}};

  typedef enum int {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } phase_mode_e;

  // Mirror of the identifier table; it predicts one result per transfer and
  // checks the results in order.
  class id_set_tracker;
    logic [ID_W-1:0] held_ids [TABLE_DEPTH];
    int              held_total = 0;
    bit              monitor_all = 1'b0;
    out_item_t       due_results [$];
    int              errors = 0;

    function int slot_of(logic [ID_W-1:0] id);
      for (int i = 0; i < held_total; i++) begin
        if (held_ids[i] == id) return i;
      end
      return held_total;
    endfunction

    function void note_request(in_item_t req);
      out_item_t r;
      int        pos;
      r = '0;
      pos = slot_of(req.group_id);
      case (req.action)
        ACT_ADD: begin
          if (req.group_id == '0) begin
            r.status = ST_INVALID;
          end else if (pos < held_total) begin
            r.status = ST_PRESENT;
          end else if (held_total >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            held_ids[held_total] = req.group_id;
            held_total++;
            r.status = ST_ADDED;
          end
        end
        ACT_REMOVE: begin
          // Drop the first match and close the gap so the order is kept.
          if (pos < held_total) begin
            for (int i = pos; i < held_total - 1; i++) held_ids[i] = held_ids[i + 1];
            held_total--;
          end
          r.status = ST_REMOVED;
        end
        default: begin
          // The spare action code behaves as a lookup.
          r.found  = monitor_all || (pos < held_total);
          r.status = ST_LOOKUP;
        end
      endcase
      r.entry_count = 8'(held_total);
      due_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%0b status=%0d count=%0d",
                 $time, got.found, got.status, got.entry_count);
        return;
      end
      want = due_results.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.entry_count !== want.entry_count) begin
        errors++;
        $display("%0t: expected found=%0b status=%0d count=%0d, actual found=%0b status=%0d count=%0d",
                 $time, want.found, want.status, want.entry_count,
                 got.found, got.status, got.entry_count);
      end
    endfunction

    function void flag_leftover();
      if (due_results.size() != 0) begin
        errors += due_results.size();
        $display("%0t: expected %0d more results, actual none", $time, due_results.size());
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  in_item_t  in_i;
  logic      res_strobe_o;
  out_item_t res_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  id_set_tracker   sb = new();
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  int              cycle_count = 0;

  bounded_id_set_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch every channel: register writes, request transfers and results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o === 1'b1) sb.monitor_all = cfg_data_i;
      if (start_i && busy_o === 1'b0) sb.note_request(in_i);
      if (res_strobe_o === 1'b1) sb.check_result(res_o);
    end
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_item_t make_req(logic [1:0] action, logic [ID_W-1:0] id);
    in_item_t item;
    item.action   = action;
    item.group_id = id;
    return item;
  endfunction

  // Held identifiers make removes and lookups hit; the pool brings back
  // identifiers seen before, and fresh ones fill the table.
  function automatic logic [ID_W-1:0] pick_id(bit adding);
    int r;
    int held_share;
    held_share = adding ? 15 : 60;
    r = $urandom_range(0, 99);
    if (r < held_share && sb.held_total > 0) return sb.held_ids[$urandom_range(0, sb.held_total - 1)];
    r = $urandom_range(0, 99);
    if (r < 40) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 90) return ID_W'($urandom);
    if (r < 95) return '0;
    case ($urandom_range(0, 3))
      0: return {{(ID_W-1){1'b0}}, 1'b1};
      1: return ID_MAX;
      2: return ID_TOP;
      default: return ID_LOW;
    endcase
  endfunction

  function automatic in_item_t make_item(phase_mode_e mode);
    int         r;
    logic [1:0] action;
    r = $urandom_range(0, 99);
    case (mode)
      PH_FILL:  action = r < 80 ? ACT_ADD : r < 85 ? ACT_REMOVE : r < 97 ? ACT_LOOKUP : ACT_SPARE;
      PH_CHURN: action = r < 35 ? ACT_ADD : r < 60 ? ACT_REMOVE : r < 95 ? ACT_LOOKUP : ACT_SPARE;
      default:  action = r < 15 ? ACT_ADD : r < 70 ? ACT_REMOVE : r < 95 ? ACT_LOOKUP : ACT_SPARE;
    endcase
    return make_req(action, pick_id(action == ACT_ADD));
  endfunction

  // Offer one request and hold it until the transfer; start_i stays high.
  task automatic send_item(in_item_t item);
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Wait for all outstanding results, then let the pipeline empty.
  task automatic settle();
    int waited;
    waited = 0;
    while (sb.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_monitor_all(bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  // Random requests in bursts with idle gaps between them.
  task automatic run_phase(phase_mode_e mode, int gap_max);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
        send_item(make_item(mode));
        sent++;
      end
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
  endtask

  // Directed cases, then random phases with a register write between them.
  initial begin
    phase_mode_e modes [PHASE_COUNT] = '{PH_FILL, PH_CHURN, PH_DRAIN, PH_FILL,
                                         PH_CHURN, PH_CHURN, PH_DRAIN, PH_FILL};
    bit          monitor_seq [PHASE_COUNT] = '{0, 1, 0, 0, 1, 1, 0, 1};
    int          gap_seq [PHASE_COUNT] = '{3, 0, 5, 2, 4, 0, 3, 6};

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom % ID_MAX) + 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, invalid identifier, duplicates, extremes, spare action code,
    // removal from the front and the middle.
    send_item(make_req(ACT_LOOKUP, '0));
    send_item(make_req(ACT_ADD, '0));
    send_item(make_req(ACT_REMOVE, '0));
    send_item(make_req(ACT_ADD, 23'd1));
    send_item(make_req(ACT_ADD, ID_MAX));
    send_item(make_req(ACT_ADD, ID_TOP));
    send_item(make_req(ACT_ADD, 23'd1));
    send_item(make_req(ACT_LOOKUP, 23'd1));
    send_item(make_req(ACT_LOOKUP, ID_MAX));
    send_item(make_req(ACT_LOOKUP, 23'h2AAAAA));
    send_item(make_req(ACT_SPARE, ID_TOP));
    send_item(make_req(ACT_SPARE, 23'h555555));
    send_item(make_req(ACT_REMOVE, 23'h2AAAAA));
    send_item(make_req(ACT_REMOVE, 23'd1));
    send_item(make_req(ACT_LOOKUP, ID_TOP));
    send_item(make_req(ACT_LOOKUP, 23'd1));
    send_item(make_req(ACT_ADD, 23'd1));
    send_item(make_req(ACT_REMOVE, ID_TOP));
    send_item(make_req(ACT_LOOKUP, '0));
    start_i <= 1'b0;
    settle();

    // With monitor-all set, every lookup reports found.
    write_monitor_all(1'b1);
    send_item(make_req(ACT_LOOKUP, '0));
    send_item(make_req(ACT_LOOKUP, 23'h555555));
    send_item(make_req(ACT_SPARE, 23'h2AAAAA));
    send_item(make_req(ACT_ADD, ID_MAX));
    start_i <= 1'b0;
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_monitor_all(monitor_seq[p]);
      @(posedge clk_i);
      run_phase(modes[p], gap_seq[p]);
      settle();
    end

    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
